// ----- rtl/ktpq_pkg.sv -----
// Shared constants, payload structs and state codes for the keyed timer queue.
// Used by every module of the block; depends on nothing.
package ktpq_pkg;

    localparam int CAPACITY     = 32;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int RESULT_LIMIT = 32;
    localparam int RES_IDX_W    = $clog2(RESULT_LIMIT);
    localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

    localparam int ACT_W  = 3;
    localparam int ID_W   = 63;
    localparam int KIND_W = 2;
    localparam int TIME_W = 32;
    localparam int LOC_W  = 32;
    localparam int STAT_W = 2;
    localparam int PCNT_W = 6;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_SCHEDULE   = 3'd0,
        ACT_CANCEL     = 3'd1,
        ACT_CANCEL_ALL = 3'd2,
        ACT_PROCESS    = 3'd3,
        ACT_LOOKUP     = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_DUE       = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // What one sweep of the slot store looks for.
    typedef enum logic [1:0] {
        SM_KEY = 2'd0,   // key match and lowest free slot
        SM_ID  = 2'd1,   // every slot of one id, cleared on the fly
        SM_MIN = 2'd2    // earliest live entry
    } t_scan_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP_SCAN,
        S_APPLY,
        S_MIN_SCAN,
        S_PROC_CHECK,
        S_FINAL,
        S_DRAIN_RD,
        S_DRAIN_WR
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] deadline;
        logic [LOC_W-1:0]  locator;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  slot;
        t_entry            data;
    } t_slot_wr;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  slot;
    } t_slot_clr;

    typedef struct packed {
        logic              live;
        logic [IDX_W-1:0]  slot;
        logic              valid;
        t_entry            data;
    } t_slot_rd;

    typedef struct packed {
        logic              start;
        t_scan_mode        mode;
    } t_scan_ctl;

    typedef struct packed {
        logic              match_found;
        logic [IDX_W-1:0]  match_slot;
        logic [TIME_W-1:0] match_time;
        logic              free_found;
        logic [IDX_W-1:0]  free_slot;
        logic              any_hit;
        logic              best_found;
        logic [IDX_W-1:0]  best_slot;
        t_entry            best;
    } t_scan_res;

endpackage

// ----- rtl/ktpq_store.sv -----
// Slot store: entry memory with a registered read port, live bits and live count.
// Depends on ktpq_pkg.
module ktpq_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [ktpq_pkg::IDX_W-1:0]    i_rd_slot,
    input  ktpq_pkg::t_slot_wr            i_wr,
    input  ktpq_pkg::t_slot_clr           i_clr,
    output ktpq_pkg::t_slot_rd            o_rd,
    output logic [ktpq_pkg::CNT_W-1:0]    o_count
);

    ktpq_pkg::t_entry                  r_mem [ktpq_pkg::CAPACITY];
    ktpq_pkg::t_entry                  r_rd_data;
    logic [ktpq_pkg::IDX_W-1:0]        r_rd_slot;
    logic                              r_rd_valid;
    logic                              r_rd_live;
    logic [ktpq_pkg::CAPACITY-1:0]     r_valid, n_valid;
    logic [ktpq_pkg::CNT_W-1:0]        r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.slot] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_slot];
            r_rd_slot  <= i_rd_slot;
            r_rd_valid <= r_valid[i_rd_slot];
        end
    end

    // Writes and clears never coincide; a write to a dead slot makes it live.
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        if (i_clr.en && r_valid[i_clr.slot]) begin
            n_valid[i_clr.slot] = 1'b0;
            n_count = r_count - ktpq_pkg::CNT_W'(1);
        end
        if (i_wr.en && !r_valid[i_wr.slot]) begin
            n_valid[i_wr.slot] = 1'b1;
            n_count = r_count + ktpq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_count   <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_rd_live <= i_rd_en;
        end
    end

    assign o_rd.live  = r_rd_live;
    assign o_rd.slot  = r_rd_slot;
    assign o_rd.valid = r_rd_valid;
    assign o_rd.data  = r_rd_data;
    assign o_count    = r_count;

endmodule

// ----- rtl/ktpq_scan.sv -----
// Shared compare unit: looks at one slot a cycle and accumulates match, free and minimum.
// Depends on ktpq_pkg.
module ktpq_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ktpq_pkg::t_scan_ctl           i_ctl,
    input  logic [ktpq_pkg::ID_W-1:0]     i_key_id,
    input  logic [ktpq_pkg::KIND_W-1:0]   i_key_kind,
    input  ktpq_pkg::t_slot_rd            i_rd,
    output ktpq_pkg::t_scan_res           o_res,
    output ktpq_pkg::t_slot_clr           o_clr
);

    ktpq_pkg::t_scan_mode r_mode;
    ktpq_pkg::t_scan_res  r_res, n_res;
    logic                 id_hit;
    logic                 key_hit;
    logic                 earlier;

    assign id_hit  = i_rd.valid && (i_rd.data.id == i_key_id);
    assign key_hit = id_hit && (i_rd.data.kind == i_key_kind);
    // Order by deadline, then id, then kind: one wide unsigned compare.
    assign earlier = {i_rd.data.deadline, i_rd.data.id, i_rd.data.kind}
                   < {r_res.best.deadline, r_res.best.id, r_res.best.kind};

    always_comb begin
        n_res = r_res;
        o_clr = '0;
        if (i_ctl.start) begin
            n_res = '0;
        end else if (i_rd.live) begin
            unique case (r_mode)
                ktpq_pkg::SM_KEY: begin
                    if (key_hit && !r_res.match_found) begin
                        n_res.match_found = 1'b1;
                        n_res.match_slot  = i_rd.slot;
                        n_res.match_time  = i_rd.data.deadline;
                    end
                    if (!i_rd.valid && !r_res.free_found) begin
                        n_res.free_found = 1'b1;
                        n_res.free_slot  = i_rd.slot;
                    end
                end
                ktpq_pkg::SM_ID: begin
                    if (id_hit) begin
                        n_res.any_hit = 1'b1;
                        o_clr.en      = 1'b1;
                        o_clr.slot    = i_rd.slot;
                    end
                end
                ktpq_pkg::SM_MIN: begin
                    if (i_rd.valid && (!r_res.best_found || earlier)) begin
                        n_res.best_found = 1'b1;
                        n_res.best_slot  = i_rd.slot;
                        n_res.best       = i_rd.data;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ktpq_pkg::SM_MIN;
            r_res  <= '0;
        end else begin
            if (i_ctl.start) begin
                r_mode <= i_ctl.mode;
            end
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/ktpq_rbuf.sv -----
// Result buffer: holds the due entries of one process run until the final state is known.
// Depends on ktpq_pkg.
module ktpq_rbuf (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [ktpq_pkg::RES_IDX_W-1:0]  i_wr_addr,
    input  ktpq_pkg::t_entry                i_wr_data,
    input  logic                            i_rd_en,
    input  logic [ktpq_pkg::RES_IDX_W-1:0]  i_rd_addr,
    output ktpq_pkg::t_entry                o_rd_data
);

    ktpq_pkg::t_entry r_mem [ktpq_pkg::RESULT_LIMIT];
    ktpq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/keyed_timer_priority_queue_top.sv -----
// Keyed timer queue top level: sequencer, input capture and output register.
// Depends on ktpq_pkg, ktpq_store, ktpq_scan and ktpq_rbuf.
//
// Timer queue of CAPACITY slots keyed by (item id, kind). Every operation is
// carried out by sweeping the slot memory one slot per cycle through a single
// shared compare unit, so the sweep length sets the pace. Schedule, cancel,
// cancel-all and lookup take one sweep to find the key (and the lowest free
// slot), an update state, and a second sweep to find the earliest pending
// entry. Process(now) runs a minimum sweep, then another one after each due
// entry is removed, then drains the buffered due entries, one read state and
// one write state per beat. Each result beat carries the pending count and
// earliest entry as they stand after the whole operation, which is why due
// entries are held in a result buffer until the final sweep is over. Input
// stall is high from the accepted beat until the last result beat has been
// loaded into the output register; a new beat may be taken while that final
// result still waits on output stall. Reset is synchronous and clears the live
// bits at once; no clearing pass is needed.
module keyed_timer_priority_queue_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ktpq_pkg::ACT_W-1:0]    i_action,
    input  logic [ktpq_pkg::ID_W-1:0]     i_item_id,
    input  logic [ktpq_pkg::KIND_W-1:0]   i_timer_kind,
    input  logic [ktpq_pkg::TIME_W-1:0]   i_time_value,
    input  logic [ktpq_pkg::LOC_W-1:0]    i_locator_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ktpq_pkg::STAT_W-1:0]   o_status,
    output logic [ktpq_pkg::ID_W-1:0]     o_out_id,
    output logic [ktpq_pkg::KIND_W-1:0]   o_out_kind,
    output logic [ktpq_pkg::TIME_W-1:0]   o_out_time,
    output logic [ktpq_pkg::LOC_W-1:0]    o_out_locator,
    output logic                          o_last_of_run,
    output logic [ktpq_pkg::PCNT_W-1:0]   o_pending_count,
    output logic                          o_next_valid,
    output logic [ktpq_pkg::TIME_W-1:0]   o_next_time,
    output logic [ktpq_pkg::ID_W-1:0]     o_next_id,
    output logic [ktpq_pkg::KIND_W-1:0]   o_next_kind
);

    // Sequencer state
    ktpq_pkg::t_state                 r_state, n_state;

    // Captured input beat
    ktpq_pkg::t_action                r_act;
    logic [ktpq_pkg::ID_W-1:0]        r_id;
    logic [ktpq_pkg::KIND_W-1:0]      r_kind;
    logic [ktpq_pkg::TIME_W-1:0]      r_tv;
    logic [ktpq_pkg::LOC_W-1:0]       r_loc;

    // Single-result outcome
    ktpq_pkg::t_status                r_status, n_status;
    logic [ktpq_pkg::ID_W-1:0]        r_res_id, n_res_id;
    logic [ktpq_pkg::KIND_W-1:0]      r_res_kind, n_res_kind;
    logic [ktpq_pkg::TIME_W-1:0]      r_res_time, n_res_time;

    // Process run bookkeeping: due entries found, and drain pointer
    logic [ktpq_pkg::RES_CNT_W-1:0]   r_n;
    logic [ktpq_pkg::RES_IDX_W-1:0]   r_k;

    // Sweep address generator
    logic [ktpq_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic                             r_issuing, n_issuing;

    // Output register
    logic                             r_ov;
    ktpq_pkg::t_status                r_o_status;
    ktpq_pkg::t_entry                 r_o_entry;
    logic                             r_o_last;
    logic [ktpq_pkg::PCNT_W-1:0]      r_o_count;
    logic                             r_o_nvalid;
    logic [ktpq_pkg::TIME_W-1:0]      r_o_ntime;
    logic [ktpq_pkg::ID_W-1:0]        r_o_nid;
    logic [ktpq_pkg::KIND_W-1:0]      r_o_nkind;

    // Interconnect
    ktpq_pkg::t_slot_rd               slot_rd;
    ktpq_pkg::t_slot_wr               slot_wr;
    ktpq_pkg::t_slot_clr              slot_clr, scan_clr, top_clr;
    ktpq_pkg::t_scan_ctl              scan_ctl;
    ktpq_pkg::t_scan_res              scan_res;
    ktpq_pkg::t_scan_mode             in_mode;
    ktpq_pkg::t_entry                 buf_rd_data;
    logic [ktpq_pkg::CNT_W-1:0]       live_count;

    logic                             in_acc;
    logic                             scan_done;
    logic                             out_free;
    logic                             due;
    logic                             drain_last;
    logic                             buf_wr_en;
    logic                             buf_rd_en;
    logic                             out_load_final;
    logic                             out_load_due;

    assign in_acc     = i_in_valid && (r_state == ktpq_pkg::S_IDLE);
    assign o_in_stall = (r_state != ktpq_pkg::S_IDLE);
    assign scan_done  = slot_rd.live && (slot_rd.slot == ktpq_pkg::LAST_SLOT);
    assign out_free   = !r_ov || !i_out_stall;

    // Emit the earliest entry while it is due and the run limit is not reached.
    assign due = (r_act == ktpq_pkg::ACT_PROCESS) && scan_res.best_found
              && (scan_res.best.deadline <= r_tv)
              && (r_n != ktpq_pkg::RES_CNT_W'(ktpq_pkg::RESULT_LIMIT));

    assign drain_last = (ktpq_pkg::RES_CNT_W'(r_k) + ktpq_pkg::RES_CNT_W'(1)) == r_n;

    // Pick the first sweep for an incoming action.
    always_comb begin
        unique case (ktpq_pkg::t_action'(i_action)) inside
            ktpq_pkg::ACT_SCHEDULE, ktpq_pkg::ACT_CANCEL, ktpq_pkg::ACT_LOOKUP:
                in_mode = ktpq_pkg::SM_KEY;
            ktpq_pkg::ACT_CANCEL_ALL:
                in_mode = ktpq_pkg::SM_ID;
            default:
                in_mode = ktpq_pkg::SM_MIN;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ktpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (in_mode == ktpq_pkg::SM_MIN) ? ktpq_pkg::S_MIN_SCAN
                                                            : ktpq_pkg::S_OP_SCAN;
                end
            end
            ktpq_pkg::S_OP_SCAN: begin
                if (scan_done) begin
                    n_state = ktpq_pkg::S_APPLY;
                end
            end
            ktpq_pkg::S_APPLY: begin
                n_state = ktpq_pkg::S_MIN_SCAN;
            end
            ktpq_pkg::S_MIN_SCAN: begin
                if (scan_done) begin
                    n_state = ktpq_pkg::S_PROC_CHECK;
                end
            end
            ktpq_pkg::S_PROC_CHECK: begin
                if (due) begin
                    n_state = ktpq_pkg::S_MIN_SCAN;
                end else if (r_n != '0) begin
                    n_state = ktpq_pkg::S_DRAIN_RD;
                end else begin
                    n_state = ktpq_pkg::S_FINAL;
                end
            end
            ktpq_pkg::S_FINAL: begin
                if (out_free) begin
                    n_state = ktpq_pkg::S_IDLE;
                end
            end
            ktpq_pkg::S_DRAIN_RD: begin
                n_state = ktpq_pkg::S_DRAIN_WR;
            end
            ktpq_pkg::S_DRAIN_WR: begin
                if (out_free) begin
                    n_state = drain_last ? ktpq_pkg::S_IDLE : ktpq_pkg::S_DRAIN_RD;
                end
            end
        endcase
    end

    // Strobes and outcome updates
    always_comb begin
        scan_ctl.start = 1'b0;
        scan_ctl.mode  = ktpq_pkg::SM_MIN;
        slot_wr.en     = 1'b0;
        slot_wr.slot   = scan_res.free_slot;
        slot_wr.data   = '{id: r_id, kind: r_kind, deadline: r_tv, locator: r_loc};
        top_clr.en     = 1'b0;
        top_clr.slot   = scan_res.best_slot;
        buf_wr_en      = 1'b0;
        buf_rd_en      = 1'b0;
        out_load_final = 1'b0;
        out_load_due   = 1'b0;
        n_status       = r_status;
        n_res_id       = r_res_id;
        n_res_kind     = r_res_kind;
        n_res_time     = r_res_time;
        unique case (r_state)
            ktpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    scan_ctl.start = 1'b1;
                    scan_ctl.mode  = in_mode;
                    n_status       = ktpq_pkg::ST_DONE;
                    n_res_id       = '0;
                    n_res_kind     = '0;
                    n_res_time     = '0;
                end
            end
            ktpq_pkg::S_APPLY: begin
                scan_ctl.start = 1'b1;
                unique case (r_act)
                    ktpq_pkg::ACT_SCHEDULE: begin
                        if (scan_res.match_found) begin
                            slot_wr.en   = 1'b1;
                            slot_wr.slot = scan_res.match_slot;
                        end else if (scan_res.free_found) begin
                            slot_wr.en   = 1'b1;
                        end else begin
                            n_status = ktpq_pkg::ST_FULL;
                        end
                    end
                    ktpq_pkg::ACT_CANCEL: begin
                        if (scan_res.match_found) begin
                            top_clr.en   = 1'b1;
                            top_clr.slot = scan_res.match_slot;
                        end else begin
                            n_status = ktpq_pkg::ST_NOT_FOUND;
                        end
                    end
                    ktpq_pkg::ACT_CANCEL_ALL: begin
                        if (!scan_res.any_hit) begin
                            n_status = ktpq_pkg::ST_NOT_FOUND;
                        end
                    end
                    ktpq_pkg::ACT_LOOKUP: begin
                        if (scan_res.match_found) begin
                            n_res_id   = r_id;
                            n_res_kind = r_kind;
                            n_res_time = scan_res.match_time;
                        end else begin
                            n_status = ktpq_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
            ktpq_pkg::S_PROC_CHECK: begin
                if (due) begin
                    buf_wr_en      = 1'b1;
                    top_clr.en     = 1'b1;
                    scan_ctl.start = 1'b1;
                end
            end
            ktpq_pkg::S_FINAL: begin
                out_load_final = out_free;
            end
            ktpq_pkg::S_DRAIN_RD: begin
                buf_rd_en = 1'b1;
            end
            ktpq_pkg::S_DRAIN_WR: begin
                out_load_due = out_free;
            end
            default: ;
        endcase
    end

    // Cancel-all clears from inside the sweep; everything else from the sequencer.
    assign slot_clr = scan_clr.en ? scan_clr : top_clr;

    // Sweep addresses: restart at slot zero, stop after the last slot.
    always_comb begin
        n_idx     = r_idx;
        n_issuing = r_issuing;
        if (scan_ctl.start) begin
            n_idx     = '0;
            n_issuing = 1'b1;
        end else if (r_issuing) begin
            n_idx     = r_idx + ktpq_pkg::IDX_W'(1);
            n_issuing = (r_idx != ktpq_pkg::LAST_SLOT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ktpq_pkg::S_IDLE;
            r_issuing <= 1'b0;
            r_idx     <= '0;
            r_n       <= '0;
            r_k       <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issuing <= n_issuing;
            r_idx     <= n_idx;
            if (in_acc) begin
                r_n <= '0;
                r_k <= '0;
            end else begin
                if (buf_wr_en) begin
                    r_n <= r_n + ktpq_pkg::RES_CNT_W'(1);
                end
                if (out_load_due && !drain_last) begin
                    r_k <= r_k + ktpq_pkg::RES_IDX_W'(1);
                end
            end
            if (out_load_final || out_load_due) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Hold the input beat and the outcome for the whole operation.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act  <= ktpq_pkg::t_action'(i_action);
            r_id   <= i_item_id;
            r_kind <= i_timer_kind;
            r_tv   <= i_time_value;
            r_loc  <= i_locator_tag;
        end
        r_status   <= n_status;
        r_res_id   <= n_res_id;
        r_res_kind <= n_res_kind;
        r_res_time <= n_res_time;
    end

    // Load the output beat; the pending summary comes from the last minimum sweep.
    always_ff @(posedge i_clk) begin
        if (out_load_final || out_load_due) begin
            r_o_count  <= ktpq_pkg::PCNT_W'(live_count);
            r_o_nvalid <= scan_res.best_found;
            r_o_ntime  <= scan_res.best_found ? scan_res.best.deadline : '0;
            r_o_nid    <= scan_res.best_found ? scan_res.best.id : '0;
            r_o_nkind  <= scan_res.best_found ? scan_res.best.kind : '0;
        end
        if (out_load_final) begin
            r_o_status         <= r_status;
            r_o_entry.id       <= r_res_id;
            r_o_entry.kind     <= r_res_kind;
            r_o_entry.deadline <= r_res_time;
            r_o_entry.locator  <= '0;
            r_o_last           <= 1'b1;
        end else if (out_load_due) begin
            r_o_status <= ktpq_pkg::ST_DUE;
            r_o_entry  <= buf_rd_data;
            r_o_last   <= drain_last;
        end
    end

    ktpq_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_issuing),
        .i_rd_slot (r_idx),
        .i_wr      (slot_wr),
        .i_clr     (slot_clr),
        .o_rd      (slot_rd),
        .o_count   (live_count)
    );

    ktpq_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_key_id   (r_id),
        .i_key_kind (r_kind),
        .i_rd       (slot_rd),
        .o_res      (scan_res),
        .o_clr      (scan_clr)
    );

    ktpq_rbuf u_rbuf (
        .i_clk     (i_clk),
        .i_wr_en   (buf_wr_en),
        .i_wr_addr (r_n[ktpq_pkg::RES_IDX_W-1:0]),
        .i_wr_data (scan_res.best),
        .i_rd_en   (buf_rd_en),
        .i_rd_addr (r_k),
        .o_rd_data (buf_rd_data)
    );

    assign o_out_valid     = r_ov;
    assign o_status        = r_o_status;
    assign o_out_id        = r_o_entry.id;
    assign o_out_kind      = r_o_entry.kind;
    assign o_out_time      = r_o_entry.deadline;
    assign o_out_locator   = r_o_entry.locator;
    assign o_last_of_run   = r_o_last;
    assign o_pending_count = r_o_count;
    assign o_next_valid    = r_o_nvalid;
    assign o_next_time     = r_o_ntime;
    assign o_next_id       = r_o_nid;
    assign o_next_kind     = r_o_nkind;

endmodule

// ----- rtl/ktpq_checker.sv -----
// Port-level checks for the keyed timer queue, bound to the top level.
// Depends on ktpq_pkg and keyed_timer_priority_queue_top.
module ktpq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [ktpq_pkg::STAT_W-1:0]   o_status,
    input logic [ktpq_pkg::ID_W-1:0]     o_out_id,
    input logic [ktpq_pkg::KIND_W-1:0]   o_out_kind,
    input logic [ktpq_pkg::TIME_W-1:0]   o_out_time,
    input logic [ktpq_pkg::LOC_W-1:0]    o_out_locator,
    input logic                          o_last_of_run,
    input logic [ktpq_pkg::PCNT_W-1:0]   o_pending_count,
    input logic                          o_next_valid,
    input logic [ktpq_pkg::TIME_W-1:0]   o_next_time,
    input logic [ktpq_pkg::ID_W-1:0]     o_next_id,
    input logic [ktpq_pkg::KIND_W-1:0]   o_next_kind
);

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_out_id) && $stable(o_out_time) && $stable(o_out_locator)
            && $stable(o_last_of_run))
        else $error("stalled result beat changed");

    // A run still being delivered is made of due entries and keeps input stalled.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> o_in_stall
            && (o_status == ktpq_pkg::ST_DUE))
        else $error("unfinished run without due status or with input open");

    // An empty queue has no pending count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_next_valid |-> (o_pending_count == '0))
        else $error("pending count without a next entry");

    // What stays pending orders strictly after every emitted entry.
    a_due_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ktpq_pkg::ST_DUE) && o_next_valid |->
            (o_next_time > o_out_time)
            || ((o_next_time == o_out_time) && (o_next_id > o_out_id))
            || ((o_next_time == o_out_time) && (o_next_id == o_out_id)
                && (o_next_kind > o_out_kind)))
        else $error("pending entry orders before an emitted entry");

endmodule

bind keyed_timer_priority_queue_top ktpq_checker u_ktpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_out_id        (o_out_id),
    .o_out_kind      (o_out_kind),
    .o_out_time      (o_out_time),
    .o_out_locator   (o_out_locator),
    .o_last_of_run   (o_last_of_run),
    .o_pending_count (o_pending_count),
    .o_next_valid    (o_next_valid),
    .o_next_time     (o_next_time),
    .o_next_id       (o_next_id),
    .o_next_kind     (o_next_kind)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for keyed_timer_priority_queue_top: a short table of timer
// operations, random ones and a fill past capacity, every reply beat checked against an
// in-bench timer store. Depends on ktpq_pkg and the block's RTL; reads no files.
`timescale 1ns / 100ps

module testbench;

    // Timer kinds and the three action codes the block leaves undefined.
    localparam logic [ktpq_pkg::KIND_W-1:0] KIND_ALARM = 2'd0;
    localparam logic [ktpq_pkg::KIND_W-1:0] KIND_READY = 2'd1;
    localparam logic [ktpq_pkg::KIND_W-1:0] KIND_FAIL  = 2'd2;
    localparam logic [ktpq_pkg::KIND_W-1:0] KIND_EXTRA = 2'd3;
    localparam logic [ktpq_pkg::ACT_W-1:0]  ACT_SPARE_5 = 3'd5;
    localparam logic [ktpq_pkg::ACT_W-1:0]  ACT_SPARE_6 = 3'd6;
    localparam logic [ktpq_pkg::ACT_W-1:0]  ACT_SPARE_7 = 3'd7;

    localparam logic [ktpq_pkg::ID_W-1:0]   ID_TOP   = {ktpq_pkg::ID_W{1'b1}};
    localparam logic [ktpq_pkg::TIME_W-1:0] TIME_TOP = {ktpq_pkg::TIME_W{1'b1}};

    localparam int RESET_CYCLES    = 6;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LIMIT    = 10;
    localparam int CYCLE_LIMIT     = 1_500_000;

    typedef struct packed {
        logic [ktpq_pkg::ACT_W-1:0]  action;
        logic [ktpq_pkg::ID_W-1:0]   id;
        logic [ktpq_pkg::KIND_W-1:0] kind;
        logic [ktpq_pkg::TIME_W-1:0] tv;
        logic [ktpq_pkg::LOC_W-1:0]  loc;
    } t_req;

    typedef struct packed {
        logic [ktpq_pkg::STAT_W-1:0] status;
        logic [ktpq_pkg::ID_W-1:0]   id;
        logic [ktpq_pkg::KIND_W-1:0] kind;
        logic [ktpq_pkg::TIME_W-1:0] dl;
        logic [ktpq_pkg::LOC_W-1:0]  loc;
        logic                        last;
        logic [ktpq_pkg::PCNT_W-1:0] count;
        logic                        nvalid;
        logic [ktpq_pkg::TIME_W-1:0] ntime;
        logic [ktpq_pkg::ID_W-1:0]   nid;
        logic [ktpq_pkg::KIND_W-1:0] nkind;
    } t_reply;

    // One line of the opening table; typed rows carry their reply written out by hand.
    typedef struct packed {
        t_req   rq;
        logic   typed;
        t_reply reply;
    } t_row;

    localparam t_reply NO_REPLY = '0;

    // Clock, reset and the block's ports.
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [ktpq_pkg::ACT_W-1:0]  in_action = '0;
    logic [ktpq_pkg::ID_W-1:0]   in_id = '0;
    logic [ktpq_pkg::KIND_W-1:0] in_kind = '0;
    logic [ktpq_pkg::TIME_W-1:0] in_time = '0;
    logic [ktpq_pkg::LOC_W-1:0]  in_loc = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [ktpq_pkg::STAT_W-1:0] out_status;
    logic [ktpq_pkg::ID_W-1:0]   out_id;
    logic [ktpq_pkg::KIND_W-1:0] out_kind;
    logic [ktpq_pkg::TIME_W-1:0] out_time;
    logic [ktpq_pkg::LOC_W-1:0]  out_loc;
    logic                        out_last;
    logic [ktpq_pkg::PCNT_W-1:0] out_count;
    logic                        out_nvalid;
    logic [ktpq_pkg::TIME_W-1:0] out_ntime;
    logic [ktpq_pkg::ID_W-1:0]   out_nid;
    logic [ktpq_pkg::KIND_W-1:0] out_nkind;

    always #1 clk = ~clk;

    keyed_timer_priority_queue_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_action        (in_action),
        .i_item_id       (in_id),
        .i_timer_kind    (in_kind),
        .i_time_value    (in_time),
        .i_locator_tag   (in_loc),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (out_status),
        .o_out_id        (out_id),
        .o_out_kind      (out_kind),
        .o_out_time      (out_time),
        .o_out_locator   (out_loc),
        .o_last_of_run   (out_last),
        .o_pending_count (out_count),
        .o_next_valid    (out_nvalid),
        .o_next_time     (out_ntime),
        .o_next_id       (out_nid),
        .o_next_kind     (out_nkind)
    );

    // Shadow copy of the slot store. Only live slots are ever read.
    logic                        tq_live [ktpq_pkg::CAPACITY];
    logic [ktpq_pkg::ID_W-1:0]   tq_id [ktpq_pkg::CAPACITY];
    logic [ktpq_pkg::KIND_W-1:0] tq_kind [ktpq_pkg::CAPACITY];
    logic [ktpq_pkg::TIME_W-1:0] tq_deadline [ktpq_pkg::CAPACITY];
    logic [ktpq_pkg::LOC_W-1:0]  tq_loc [ktpq_pkg::CAPACITY];

    t_reply replies_owed [$];
    t_row   script [$];

    // Run bookkeeping and the knobs shared between sender and receiver.
    int   cycle_count = 0;
    int   mismatches = 0;
    int   requests_sent = 0;
    int   replies_checked = 0;
    int   full_seen = 0;
    int   longest_run = 0;
    bit   sender_steady = 1'b0;
    bit   reply_steady = 1'b0;
    bit   hold_off_req = 1'b0;
    logic [ktpq_pkg::ID_W-1:0]   id_pool [8];
    logic [ktpq_pkg::TIME_W-1:0] sim_now;

    // Ordering of two live slots: deadline first, then id, then kind.
    function automatic bit orders_first(int a, int b);
        if (tq_deadline[a] != tq_deadline[b])
            return tq_deadline[a] < tq_deadline[b];
        if (tq_id[a] != tq_id[b])
            return tq_id[a] < tq_id[b];
        return tq_kind[a] < tq_kind[b];
    endfunction

    function automatic int earliest_slot();
        int best;
        int i;
        best = -1;
        for (i = 0; i < ktpq_pkg::CAPACITY; i++)
            if (tq_live[i] && (best < 0 || orders_first(i, best)))
                best = i;
        return best;
    endfunction

    function automatic int key_slot(logic [ktpq_pkg::ID_W-1:0] id,
                                    logic [ktpq_pkg::KIND_W-1:0] kind);
        int i;
        for (i = 0; i < ktpq_pkg::CAPACITY; i++)
            if (tq_live[i] && tq_id[i] == id && tq_kind[i] == kind)
                return i;
        return -1;
    endfunction

    function automatic int free_slot();
        int i;
        for (i = 0; i < ktpq_pkg::CAPACITY; i++)
            if (!tq_live[i])
                return i;
        return -1;
    endfunction

    // Apply one request to the shadow store and queue the reply beats it owes.
    // A typed row replaces the computed beat with the one written in the table.
    task automatic timer_queue_step(input t_req rq, input bit typed, input t_reply typed_reply);
        t_reply emitted [ktpq_pkg::RESULT_LIMIT];
        t_reply r;
        int     n;
        int     s;
        int     i;
        int     live;
        bit     hit;
        n = 0;
        r = '0;
        r.status = ktpq_pkg::ST_DONE;
        case (rq.action)
            ktpq_pkg::ACT_SCHEDULE: begin
                s = key_slot(rq.id, rq.kind);
                if (s < 0)
                    s = free_slot();
                if (s < 0) begin
                    r.status = ktpq_pkg::ST_FULL;
                    full_seen++;
                end else begin
                    tq_live[s] = 1'b1;
                    tq_id[s] = rq.id;
                    tq_kind[s] = rq.kind;
                    tq_deadline[s] = rq.tv;
                    tq_loc[s] = rq.loc;
                end
            end
            ktpq_pkg::ACT_CANCEL: begin
                s = key_slot(rq.id, rq.kind);
                if (s >= 0)
                    tq_live[s] = 1'b0;
                else
                    r.status = ktpq_pkg::ST_NOT_FOUND;
            end
            ktpq_pkg::ACT_CANCEL_ALL: begin
                hit = 1'b0;
                for (i = 0; i < ktpq_pkg::CAPACITY; i++) begin
                    if (tq_live[i] && tq_id[i] == rq.id) begin
                        tq_live[i] = 1'b0;
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    r.status = ktpq_pkg::ST_NOT_FOUND;
            end
            ktpq_pkg::ACT_PROCESS: begin
                // Pop due entries in order, at most one full run per request.
                s = earliest_slot();
                while (n < ktpq_pkg::RESULT_LIMIT && s >= 0 && tq_deadline[s] <= rq.tv) begin
                    emitted[n] = '0;
                    emitted[n].status = ktpq_pkg::ST_DUE;
                    emitted[n].id = tq_id[s];
                    emitted[n].kind = tq_kind[s];
                    emitted[n].dl = tq_deadline[s];
                    emitted[n].loc = tq_loc[s];
                    tq_live[s] = 1'b0;
                    n++;
                    s = earliest_slot();
                end
                if (n > longest_run)
                    longest_run = n;
            end
            ktpq_pkg::ACT_LOOKUP: begin
                s = key_slot(rq.id, rq.kind);
                if (s >= 0) begin
                    r.id = tq_id[s];
                    r.kind = tq_kind[s];
                    r.dl = tq_deadline[s];
                end else begin
                    r.status = ktpq_pkg::ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        if (n == 0) begin
            emitted[0] = r;
            n = 1;
        end

        // Every beat shows the store as it stands after the whole request.
        live = 0;
        for (i = 0; i < ktpq_pkg::CAPACITY; i++)
            if (tq_live[i])
                live++;
        s = earliest_slot();
        for (i = 0; i < n; i++) begin
            r = emitted[i];
            r.last = (i == n - 1);
            r.count = live[ktpq_pkg::PCNT_W-1:0];
            r.nvalid = (s >= 0);
            r.ntime = (s >= 0) ? tq_deadline[s] : '0;
            r.nid = (s >= 0) ? tq_id[s] : '0;
            r.nkind = (s >= 0) ? tq_kind[s] : '0;
            replies_owed.insert(replies_owed.size(), typed ? typed_reply : r);
        end
    endtask

    function automatic t_req mk_req(logic [ktpq_pkg::ACT_W-1:0] action,
                                    logic [ktpq_pkg::ID_W-1:0] id,
                                    logic [ktpq_pkg::KIND_W-1:0] kind,
                                    logic [ktpq_pkg::TIME_W-1:0] tv,
                                    logic [ktpq_pkg::LOC_W-1:0] loc);
        t_req rq;
        rq.action = action;
        rq.id = id;
        rq.kind = kind;
        rq.tv = tv;
        rq.loc = loc;
        return rq;
    endfunction

    // A single-beat reply with the out fields clear, as typed into the table.
    function automatic t_reply plain_reply(logic [ktpq_pkg::STAT_W-1:0] status, int count,
                                           bit nvalid, logic [ktpq_pkg::TIME_W-1:0] ntime,
                                           logic [ktpq_pkg::ID_W-1:0] nid,
                                           logic [ktpq_pkg::KIND_W-1:0] nkind);
        t_reply r;
        r = '0;
        r.status = status;
        r.last = 1'b1;
        r.count = count[ktpq_pkg::PCNT_W-1:0];
        r.nvalid = nvalid;
        r.ntime = ntime;
        r.nid = nid;
        r.nkind = nkind;
        return r;
    endfunction

    function automatic void add_row(t_req rq, bit typed, t_reply reply);
        t_row row;
        row.rq = rq;
        row.typed = typed;
        row.reply = reply;
        script.insert(script.size(), row);
    endfunction

    function automatic logic [ktpq_pkg::ID_W-1:0] wide_id();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[ktpq_pkg::ID_W-1:0];
    endfunction

    // Mostly ids from a small pool so that keys collide; now and then a fresh one.
    function automatic t_req random_request();
        t_req rq;
        int   pick;
        pick = $urandom_range(0, 99);
        rq.id = ($urandom_range(0, 9) == 0) ? wide_id() : id_pool[$urandom_range(0, 7)];
        rq.kind = ($urandom_range(0, 9) == 0) ? KIND_EXTRA
                                              : ktpq_pkg::KIND_W'($urandom_range(0, 2));
        rq.loc = $urandom;
        case ($urandom_range(0, 19))
            0:       rq.tv = '0;
            1:       rq.tv = TIME_TOP;
            2:       rq.tv = $urandom;
            default: rq.tv = sim_now + ktpq_pkg::TIME_W'($urandom_range(0, 60));
        endcase
        if (pick < 40) begin
            rq.action = ktpq_pkg::ACT_SCHEDULE;
        end else if (pick < 52) begin
            rq.action = ktpq_pkg::ACT_CANCEL;
        end else if (pick < 60) begin
            rq.action = ktpq_pkg::ACT_CANCEL_ALL;
        end else if (pick < 78) begin
            // Advance the notion of now, with the odd jump to an extreme.
            rq.action = ktpq_pkg::ACT_PROCESS;
            sim_now = sim_now + ktpq_pkg::TIME_W'($urandom_range(0, 40));
            case ($urandom_range(0, 19))
                0:       rq.tv = TIME_TOP;
                1:       rq.tv = $urandom;
                2:       rq.tv = '0;
                default: rq.tv = sim_now;
            endcase
        end else if (pick < 95) begin
            rq.action = ktpq_pkg::ACT_LOOKUP;
        end else begin
            case ($urandom_range(0, 2))
                0:       rq.action = ACT_SPARE_5;
                1:       rq.action = ACT_SPARE_6;
                default: rq.action = ACT_SPARE_7;
            endcase
        end
        return rq;
    endfunction

    // Offer one beat after a random gap, hold it until taken, then book its replies.
    // Valid is never lowered and raised in the same step.
    task automatic offer(input t_req rq, input bit typed, input t_reply typed_reply);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_action <= rq.action;
        in_id <= rq.id;
        in_kind <= rq.kind;
        in_time <= rq.tv;
        in_loc <= rq.loc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        timer_queue_step(rq, typed, typed_reply);
    endtask

    // Drop valid and wait for every owed reply beat to arrive.
    task automatic idle_until_drained();
        in_valid <= 1'b0;
        while (replies_owed.size() != 0)
            @(posedge clk);
    endtask

    task automatic show_reply(input string tag, input t_reply r);
        $display("  %s st=%0d id=%h kind=%0d dl=%h loc=%h last=%b cnt=%0d next=%b/%h/%h/%0d",
                 tag, r.status, r.id, r.kind, r.dl, r.loc, r.last, r.count,
                 r.nvalid, r.ntime, r.nid, r.nkind);
    endtask

    // Compare one accepted reply beat, field by field, with the oldest one owed.
    task automatic check_beat();
        t_reply got;
        t_reply want;
        bit     bad;
        got.status = out_status;
        got.id = out_id;
        got.kind = out_kind;
        got.dl = out_time;
        got.loc = out_loc;
        got.last = out_last;
        got.count = out_count;
        got.nvalid = out_nvalid;
        got.ntime = out_ntime;
        got.nid = out_nid;
        got.nkind = out_nkind;
        replies_checked++;
        if (replies_owed.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("cycle %0d: reply beat with nothing owed", cycle_count);
                show_reply("got ", got);
            end
        end else begin
            want = replies_owed.pop_front();
            bad = (got.status !== want.status) || (got.id !== want.id)
                || (got.kind !== want.kind) || (got.dl !== want.dl)
                || (got.loc !== want.loc) || (got.last !== want.last)
                || (got.count !== want.count) || (got.nvalid !== want.nvalid)
                || (got.ntime !== want.ntime) || (got.nid !== want.nid)
                || (got.nkind !== want.nkind);
            if (bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("cycle %0d: reply beat mismatch", cycle_count);
                    show_reply("want", want);
                    show_reply("got ", got);
                end
            end
        end
    endtask

    // Receiver: sample at the edge, then draw how long to stall before the next beat.
    // A hold-off request from the stimulus stalls for a long stretch so the block
    // backs up and stalls its own input.
    initial begin : reply_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                check_beat();
                if ($urandom_range(0, 15) == 0)
                    reply_steady = !reply_steady;
                hold = reply_steady ? 0 : $urandom_range(0, 10);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = HOLD_OFF_CYCLES;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles and give up well beyond the slowest legal run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles with %0d reply beats owed",
                 cycle_count, replies_owed.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_row                        row;
        t_req                        rq;
        logic [ktpq_pkg::ID_W-1:0]   burst_id;
        logic [ktpq_pkg::TIME_W-1:0] burst_time;
        int                          i;

        for (i = 0; i < ktpq_pkg::CAPACITY; i++)
            tq_live[i] = 1'b0;
        id_pool[0] = '0;
        id_pool[1] = ID_TOP;
        for (i = 2; i < 8; i++)
            id_pool[i] = wide_id();
        sim_now = $urandom;

        // Hold reset, then release it for good.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening table: empty store, extremes of every field, updates, every action,
        // the spare action codes, kind three under cancel-all, and multi-beat runs.
        add_row(mk_req(ktpq_pkg::ACT_PROCESS, '0, KIND_ALARM, '0, '0), 1'b1,
                plain_reply(ktpq_pkg::ST_DONE, 0, 1'b0, '0, '0, '0));
        add_row(mk_req(ktpq_pkg::ACT_LOOKUP, 63'd5, KIND_ALARM, '0, '0), 1'b1,
                plain_reply(ktpq_pkg::ST_NOT_FOUND, 0, 1'b0, '0, '0, '0));
        add_row(mk_req(ktpq_pkg::ACT_CANCEL, 63'd5, KIND_READY, '0, '0), 1'b1,
                plain_reply(ktpq_pkg::ST_NOT_FOUND, 0, 1'b0, '0, '0, '0));
        add_row(mk_req(ktpq_pkg::ACT_CANCEL_ALL, 63'd5, KIND_ALARM, '0, '0), 1'b1,
                plain_reply(ktpq_pkg::ST_NOT_FOUND, 0, 1'b0, '0, '0, '0));
        add_row(mk_req(ktpq_pkg::ACT_SCHEDULE, ID_TOP, KIND_FAIL, TIME_TOP, '1), 1'b1,
                plain_reply(ktpq_pkg::ST_DONE, 1, 1'b1, TIME_TOP, ID_TOP, KIND_FAIL));
        add_row(mk_req(ktpq_pkg::ACT_SCHEDULE, '0, KIND_ALARM, '0, '0), 1'b1,
                plain_reply(ktpq_pkg::ST_DONE, 2, 1'b1, '0, '0, KIND_ALARM));
        add_row(mk_req(ktpq_pkg::ACT_SCHEDULE, 63'd7, KIND_EXTRA, 32'd100, 32'hA5A5_A5A5),
                1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_SCHEDULE, 63'd7, KIND_READY, 32'd100, 32'h5A5A_5A5A),
                1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_SCHEDULE, 63'd7, KIND_ALARM, 32'd50, 32'd1),
                1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_SCHEDULE, 63'd7, KIND_ALARM, 32'd200, 32'd2),
                1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_LOOKUP, 63'd7, KIND_ALARM, '0, '0), 1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_LOOKUP, ID_TOP, KIND_FAIL, '0, '0), 1'b0, NO_REPLY);
        add_row(mk_req(ACT_SPARE_5, 63'd7, KIND_ALARM, 32'd100, '0), 1'b0, NO_REPLY);
        add_row(mk_req(ACT_SPARE_6, ID_TOP, KIND_EXTRA, TIME_TOP, '1), 1'b0, NO_REPLY);
        add_row(mk_req(ACT_SPARE_7, '0, KIND_FAIL, '0, '0), 1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_SCHEDULE, 63'd9, KIND_EXTRA, 32'd100, 32'd3),
                1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_SCHEDULE, 63'd9, KIND_READY, 32'd30, 32'd4),
                1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_CANCEL, 63'd7, KIND_READY, '0, '0), 1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_CANCEL_ALL, 63'd9, KIND_ALARM, '0, '0), 1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_PROCESS, '0, KIND_ALARM, 32'd100, '0), 1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_CANCEL, 63'd7, KIND_ALARM, '0, '0), 1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_PROCESS, '0, KIND_ALARM, TIME_TOP, '0), 1'b0, NO_REPLY);
        add_row(mk_req(ktpq_pkg::ACT_PROCESS, '0, KIND_ALARM, '0, '0), 1'b1,
                plain_reply(ktpq_pkg::ST_DONE, 0, 1'b0, '0, '0, '0));

        for (i = 0; i < script.size(); i++) begin
            row = script[i];
            offer(row.rq, row.typed, row.reply);
        end

        // Random traffic over a small key space so updates, hits and due runs are common.
        for (i = 0; i < 25; i++) begin
            if ($urandom_range(0, 7) == 0)
                sender_steady = !sender_steady;
            offer(random_request(), 1'b0, NO_REPLY);
        end

        // Pause the sender until every owed beat is back.
        idle_until_drained();

        // Empty the store, then fill it past capacity back to back while the receiver
        // holds off. Four kinds per id and close deadlines exercise every tie-break.
        offer(mk_req(ktpq_pkg::ACT_PROCESS, '0, KIND_ALARM, TIME_TOP, '0), 1'b0, NO_REPLY);
        burst_id = wide_id();
        burst_time = ktpq_pkg::TIME_W'($urandom_range(0, 32'hFFFF_FF00));
        sender_steady = 1'b1;
        hold_off_req = 1'b1;
        for (i = 0; i < ktpq_pkg::CAPACITY + 2; i++) begin
            rq = mk_req(ktpq_pkg::ACT_SCHEDULE, burst_id + ktpq_pkg::ID_W'(i / 4),
                        ktpq_pkg::KIND_W'(i % 4),
                        burst_time + ktpq_pkg::TIME_W'($urandom_range(0, 7)), $urandom);
            offer(rq, 1'b0, NO_REPLY);
        end
        offer(mk_req(ktpq_pkg::ACT_LOOKUP, burst_id + 63'd1, KIND_FAIL, '0, '0),
              1'b0, NO_REPLY);
        offer(mk_req(ktpq_pkg::ACT_SCHEDULE, burst_id, KIND_ALARM, burst_time + 32'd7,
                     $urandom), 1'b0, NO_REPLY);
        // Everything is due now: the longest run the block can give.
        offer(mk_req(ktpq_pkg::ACT_PROCESS, '0, KIND_ALARM, burst_time + 32'd7, '0),
              1'b0, NO_REPLY);
        sender_steady = 1'b0;

        for (i = 0; i < 20; i++) begin
            if ($urandom_range(0, 7) == 0)
                sender_steady = !sender_steady;
            offer(random_request(), 1'b0, NO_REPLY);
        end

        // Let the last replies out, then wait for anything stray before reporting.
        idle_until_drained();
        repeat (3 * ktpq_pkg::CAPACITY) @(posedge clk);

        $display("Sent %0d timer requests (%0d from the table), checked %0d reply beats.",
                 requests_sent, script.size(), replies_checked);
        $display("Full-table rejections %0d, longest due run %0d, mismatches %0d.",
                 full_seen, longest_run, mismatches);
        if (mismatches == 0 && replies_owed.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- keyed_timer_priority_queue_top.f -----
rtl/ktpq_pkg.sv
rtl/ktpq_store.sv
rtl/ktpq_scan.sv
rtl/ktpq_rbuf.sv
rtl/keyed_timer_priority_queue_top.sv
rtl/ktpq_checker.sv
tb/sv/testbench.sv
